>>> sv/assert_macros.svh
// assertion helpers for the rtl files, included by dndc_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen at a rising clk edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> sv/dndc_pkg.sv
`timescale 1ns / 1ps

package dndc_pkg;

  localparam int unsigned FIRST_YEAR_INT = 1901;
  localparam int unsigned LAST_YEAR_INT  = 2099;
  localparam int unsigned SPAN_YEARS     = LAST_YEAR_INT - 1900;
  localparam int unsigned LAST_DAY_INT   = SPAN_YEARS * 365 + SPAN_YEARS / 4;

  localparam logic [11:0] FIRST_YEAR = 12'(FIRST_YEAR_INT);
  localparam logic [11:0] LAST_YEAR  = 12'(LAST_YEAR_INT);
  localparam logic [16:0] LAST_DAY   = 17'(LAST_DAY_INT);
  localparam logic [3:0]  LAST_MONTH = 4'd12;
  localparam logic [3:0]  DEC_INDEX  = 4'd11;
  // 1 jan 1901 is a tuesday
  localparam logic [2:0]  FIRST_WD   = 3'd2;

  localparam logic        OP_DATE_TO_NUM = 1'b0;
  localparam logic        OP_NUM_TO_DATE = 1'b1;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  typedef struct packed {
    logic        op;
    logic [16:0] day_count;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } dndc_req_t;

  typedef struct packed {
    logic [16:0] day_count;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic        error;
  } dndc_res_t;

  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00);
  endfunction

  function automatic logic [8:0] year_len(input logic [11:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  // m0 counts months from 0 (january)
  function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m0);
    logic [4:0] len;
    case (m0)
      4'd1: begin
        len = is_leap(y) ? 5'd29 : 5'd28;
      end
      4'd3, 4'd5, 4'd8, 4'd10: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

  // weekday advance, step below 7
  function automatic logic [2:0] wd_add(input logic [2:0] w, input logic [1:0] a);
    logic [3:0] s;
    s = {1'b0, w} + {2'b00, a};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // small remainder by 7, input at most 36
  function automatic logic [2:0] mod7_small(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 6'd7) begin
        r = r - 6'd7;
      end
    end
    return r[2:0];
  endfunction

endpackage

>>> sv/dndc_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dndc_core import dndc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dndc_req_t req,
  input  logic      out_free,
  output logic      idle,
  output logic      res_valid,
  output dndc_res_t res
);

  typedef enum logic [3:0] {
    IDLE, FWD_YEAR, FWD_MONTH, ADD_DAY, DEC, CHECK,
    NORM, REV_YEAR, REV_MONTH, FINISH, DONE
  } state_t;

  state_t      state;
  logic        op;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [16:0] acc;
  logic [16:0] dn;
  logic [11:0] yy;
  logic [3:0]  m0;
  logic [4:0]  off;
  logic [2:0]  wd;
  logic [2:0]  wk;
  logic        err;

  // shared add / subtract unit
  logic [16:0] alu_a;
  logic [16:0] alu_b;
  logic        alu_sub;
  logic [17:0] alu_sum;
  logic        alu_ge;
  logic [4:0]  mlen;
  logic        bad_date;

  assign mlen = month_len(yy, m0);

  always_comb begin
    alu_a   = (state == NORM) ? {12'd0, off} : acc;
    alu_sub = state inside {REV_YEAR, REV_MONTH, NORM, DEC, CHECK};
    case (state)
      FWD_YEAR, REV_YEAR: begin
        alu_b = {8'd0, year_len(yy)};
      end
      FWD_MONTH, REV_MONTH, NORM: begin
        alu_b = {12'd0, mlen};
      end
      ADD_DAY: begin
        alu_b = {12'd0, day_r};
      end
      DEC: begin
        alu_b = 17'd1;
      end
      CHECK: begin
        alu_b = LAST_DAY;
      end
      default: begin
        alu_b = '0;
      end
    endcase
    alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
    alu_ge  = !alu_sum[17];
  end

  assign bad_date = (req.op == OP_DATE_TO_NUM) &&
                    ((req.year < FIRST_YEAR) || (req.year > LAST_YEAR) ||
                     (req.month == 4'd0) || (req.month > LAST_MONTH) || (req.day == 5'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            op      <= req.op;
            year_r  <= req.year;
            month_r <= req.month;
            day_r   <= req.day;
            acc     <= (req.op == OP_NUM_TO_DATE) ? req.day_count : 17'd0;
            dn      <= '0;
            yy      <= FIRST_YEAR;
            m0      <= 4'd0;
            wd      <= FIRST_WD;
            off     <= req.day - 5'd1;
            err     <= bad_date;
            if (bad_date) begin
              state <= DONE;
            end else if (req.op == OP_NUM_TO_DATE) begin
              state <= DEC;
            end else begin
              state <= FWD_YEAR;
            end
          end
        end
        FWD_YEAR: begin
          if (yy < year_r) begin
            acc <= alu_sum[16:0];
            yy  <= yy + 12'd1;
            wd  <= wd_add(wd, is_leap(yy) ? 2'd2 : 2'd1);
          end else begin
            state <= FWD_MONTH;
          end
        end
        FWD_MONTH: begin
          if ((m0 + 4'd1) < month_r) begin
            acc <= alu_sum[16:0];
            m0  <= m0 + 4'd1;
            wd  <= wd_add(wd, 2'(mlen - 5'd28));
          end else begin
            state <= ADD_DAY;
          end
        end
        ADD_DAY: begin
          acc   <= alu_sum[16:0];
          state <= DEC;
        end
        DEC: begin
          // day number is kept, acc becomes the zero-based offset
          dn  <= acc;
          acc <= alu_sum[16:0];
          if (!alu_ge) begin
            err   <= 1'b1;
            state <= DONE;
          end else begin
            state <= CHECK;
          end
        end
        CHECK: begin
          if (alu_ge) begin
            err   <= 1'b1;
            state <= DONE;
          end else if (op == OP_NUM_TO_DATE) begin
            state <= REV_YEAR;
          end else begin
            state <= NORM;
          end
        end
        NORM: begin
          // day past month end rolls into the next month, never past december
          if (alu_ge) begin
            off <= alu_sum[4:0];
            m0  <= m0 + 4'd1;
            wd  <= wd_add(wd, 2'(mlen - 5'd28));
          end
          state <= FINISH;
        end
        REV_YEAR: begin
          if (alu_ge && (yy < LAST_YEAR)) begin
            acc <= alu_sum[16:0];
            yy  <= yy + 12'd1;
            wd  <= wd_add(wd, is_leap(yy) ? 2'd2 : 2'd1);
          end else begin
            state <= REV_MONTH;
          end
        end
        REV_MONTH: begin
          if ((m0 < DEC_INDEX) && alu_ge) begin
            acc <= alu_sum[16:0];
            m0  <= m0 + 4'd1;
            wd  <= wd_add(wd, 2'(mlen - 5'd28));
          end else begin
            off   <= acc[4:0];
            state <= FINISH;
          end
        end
        FINISH: begin
          wk    <= mod7_small({3'd0, wd} + {1'b0, off});
          state <= DONE;
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign idle      = (state == IDLE);
  assign res_valid = (state == DONE);

  always_comb begin
    res       = '0;
    res.error = err;
    if (!err) begin
      res.day_count = dn;
      res.year      = yy;
      res.month     = m0 + 4'd1;
      res.day       = off + 5'd1;
      res.weekday   = wk;
    end
  end

  `ASSERT_CLK(a_start_idle, start |-> state == IDLE, "word taken while busy")
  `ASSERT_CLK(a_done_hold, (state == DONE && !out_free) |=> state == DONE, "result lost")
  `ASSERT_CLK(a_year_cap, (state == REV_YEAR || state == REV_MONTH) |-> yy <= LAST_YEAR, "year past range")
  `ASSERT_CLK(a_month_cap, (state == REV_MONTH || state == NORM) |-> m0 <= DEC_INDEX, "month past december")
  `ASSERT_NEVER(a_day_zero, res_valid && !res.error && res.day == 5'd0, "day of month wrapped")

endmodule

>>> sv/day_number_date_converter_top.sv
`timescale 1ns / 1ps

// channel | direction | tdata                                       | tuser
// s       | in        | day_count_in, year_in, month_in, day_in     | operation
// m       | out       | day_count_out, year_out, month_out, day_out, | error
//         |           | weekday                                     |
//
// one word at a time through a single shared 17 bit add / subtract unit, one year or
// one month per cycle; a date word walks years, then months, then adds the day, steps
// down to a zero-based offset, checks the range and folds a day past month end; a day number
// steps down, checks the range, then walks years and months; a bad date field skips to the result
// s_tready is high whenever the sequencer is idle, also while a result waits
// in the m register; a stalled m side holds the finished result in the core
// rst is synchronous, active high, and clears the sequencer and m_tvalid only

module day_number_date_converter_top import dndc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // day_count_in[16:0], year_in[28:17], month_in[32:29], day_in[37:33], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // day_count_out[16:0], year_out[28:17], month_out[32:29], day_out[37:33],
  // weekday[40:38], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // error[0]
  output logic                  m_tuser
);

  dndc_req_t req;
  dndc_res_t res;
  logic      start;
  logic      idle;
  logic      res_valid;
  logic      out_free;

  // unpack the input word
  assign req.op        = s_tuser;
  assign req.day_count = s_tdata[16:0];
  assign req.year      = s_tdata[28:17];
  assign req.month     = s_tdata[32:29];
  assign req.day       = s_tdata[37:33];

  assign s_tready = idle;
  assign start    = s_tvalid && s_tready;
  // m register is empty or is being emptied this cycle
  assign out_free = !m_tvalid || m_tready;

  dndc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .out_free  (out_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      m_tdata <= {7'd0, res.weekday, res.day, res.month, res.year, res.day_count};
      m_tuser <= res.error;
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dndc_pkg::*;

  // run length and safety net
  localparam int unsigned RANDOM_WORDS = 930;
  localparam int unsigned QUIET_WORDS  = 150;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // independent model of the converter plus the queue of results still owed
  class date_scoreboard;
    dndc_res_t owed_q[$];
    int unsigned mismatches;
    int unsigned words_in;
    int unsigned results_checked;
    int unsigned error_results;
    int unsigned to_number_words;

    function new();
      mismatches      = 0;
      words_in        = 0;
      results_checked = 0;
      error_results   = 0;
      to_number_words = 0;
    endfunction

    function int unsigned days_of_year(int unsigned y);
      return (y % 4 == 0) ? 366 : 365;
    endfunction

    // m0 counts from 0 for january
    function int unsigned days_of_month(int unsigned y, int unsigned m0);
      int unsigned n;
      case (m0)
        1: begin
          n = (y % 4 == 0) ? 29 : 28;
        end
        3, 5, 8, 10: begin
          n = 30;
        end
        default: begin
          n = 31;
        end
      endcase
      return n;
    endfunction

    function dndc_res_t convert(logic op, logic [16:0] num_in, logic [11:0] y_in,
                                logic [3:0] m_in, logic [4:0] d_in);
      dndc_res_t r;
      int unsigned dn;
      int unsigned yy;
      int unsigned m0;
      int unsigned rem;
      bit bad;
      r   = '0;
      bad = 0;
      dn  = 0;
      if (op == OP_DATE_TO_NUM) begin
        if (y_in < FIRST_YEAR_INT || y_in > LAST_YEAR_INT || m_in == 0 || m_in > 12 ||
            d_in == 0) begin
          bad = 1;
        end else begin
          for (yy = FIRST_YEAR_INT; yy < y_in; yy++) dn += days_of_year(yy);
          for (m0 = 0; m0 + 1 < m_in; m0++) dn += days_of_month(y_in, m0);
          dn += d_in;
          if (dn > LAST_DAY_INT) bad = 1;
        end
      end else begin
        dn = num_in;
        if (dn == 0 || dn > LAST_DAY_INT) bad = 1;
      end
      if (bad) begin
        r.error = 1'b1;
        return r;
      end
      // walk whole years, then whole months
      rem = dn - 1;
      yy  = FIRST_YEAR_INT;
      while (rem >= days_of_year(yy) && yy < LAST_YEAR_INT) begin
        rem -= days_of_year(yy);
        yy++;
      end
      m0 = 0;
      while (m0 < 11 && rem >= days_of_month(yy, m0)) begin
        rem -= days_of_month(yy, m0);
        m0++;
      end
      r.day_count = dn[16:0];
      r.year      = yy[11:0];
      r.month     = 4'(m0 + 1);
      r.day       = 5'(rem + 1);
      r.weekday   = 3'((dn + 1) % 7);
      r.error     = 1'b0;
      return r;
    endfunction

    function void note_word(logic op, logic [16:0] num_in, logic [11:0] y_in,
                            logic [3:0] m_in, logic [4:0] d_in);
      owed_q.push_back(convert(op, num_in, y_in, m_in, d_in));
      words_in++;
      if (op == OP_DATE_TO_NUM) to_number_words++;
    endfunction

    function void check_result(dndc_res_t got);
      dndc_res_t exp_r;
      if (owed_q.size() == 0) begin
        $error("result word with nothing owed: day_count_out %0d error %0d",
               got.day_count, got.error);
        mismatches++;
        return;
      end
      exp_r = owed_q.pop_front();
      results_checked++;
      if (exp_r.error) error_results++;
      if (got.day_count !== exp_r.day_count) begin
        $error("day_count_out: expected %0d, got %0d", exp_r.day_count, got.day_count);
        mismatches++;
      end
      if (got.year !== exp_r.year) begin
        $error("year_out: expected %0d, got %0d", exp_r.year, got.year);
        mismatches++;
      end
      if (got.month !== exp_r.month) begin
        $error("month_out: expected %0d, got %0d", exp_r.month, got.month);
        mismatches++;
      end
      if (got.day !== exp_r.day) begin
        $error("day_out: expected %0d, got %0d", exp_r.day, got.day);
        mismatches++;
      end
      if (got.weekday !== exp_r.weekday) begin
        $error("weekday: expected %0d, got %0d", exp_r.weekday, got.weekday);
        mismatches++;
      end
      if (got.error !== exp_r.error) begin
        $error("error: expected %0d, got %0d", exp_r.error, got.error);
        mismatches++;
      end
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // set for the closing stretch: no gaps, no stalls
  bit quiet = 1'b0;
  int unsigned cycle_count = 0;
  date_scoreboard sb = new();

  day_number_date_converter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: unpack each accepted word and hand it to the scoreboard
  always @(posedge clk) begin
    dndc_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.day_count = m_tdata[16:0];
      got.year      = m_tdata[28:17];
      got.month     = m_tdata[32:29];
      got.day       = m_tdata[37:33];
      got.weekday   = m_tdata[40:38];
      got.error     = m_tuser;
      sb.check_result(got);
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    int unsigned hold;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(1, 7);
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // present one word, optionally after a gap, and hold it until taken
  task automatic send_word(input logic op, input logic [16:0] num_in, input logic [11:0] y_in,
                           input logic [3:0] m_in, input logic [4:0] d_in);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    // tdata: day_count_in, year_in, month_in, day_in from bit 0 up, zero fill
    s_tdata  <= {2'b00, d_in, m_in, y_in, num_in};
    do @(posedge clk); while (!s_tready);
    sb.note_word(op, num_in, y_in, m_in, d_in);
  endtask

  // date to number, with a random day number in the ignored field
  task automatic send_date(input logic [11:0] y_in, input logic [3:0] m_in,
                           input logic [4:0] d_in);
    send_word(OP_DATE_TO_NUM, 17'($urandom), y_in, m_in, d_in);
  endtask

  // number to date, with random date fields in the ignored slots
  task automatic send_number(input logic [16:0] num_in);
    send_word(OP_NUM_TO_DATE, num_in, 12'($urandom), 4'($urandom), 5'($urandom));
  endtask

  // sender holds off until every owed result is back
  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
  endtask

  // one random word, mostly legal values with some anywhere in the field range
  task automatic send_random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      if (pick < 85) begin
        send_date(12'($urandom_range(FIRST_YEAR_INT, LAST_YEAR_INT)),
                  4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)));
      end else begin
        send_date(12'($urandom), 4'($urandom), 5'($urandom));
      end
    end else begin
      if (pick < 85) begin
        send_number(17'($urandom_range(1, LAST_DAY_INT)));
      end else if (pick < 95) begin
        send_number(17'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0: send_number(17'd0);
          1: send_number(LAST_DAY);
          default: send_number(LAST_DAY + 17'd1);
        endcase
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: limits of each date field and the rollover cases
    send_date(12'd1901, 4'd1, 5'd1);
    send_date(12'd2099, 4'd12, 5'd31);
    send_date(12'd1900, 4'd1, 5'd1);
    send_date(12'd2100, 4'd1, 5'd1);
    send_date(12'd0, 4'd0, 5'd0);
    send_date(12'd4095, 4'd15, 5'd31);
    send_date(12'd1950, 4'd0, 5'd10);
    send_date(12'd1950, 4'd13, 5'd10);
    send_date(12'd1950, 4'd6, 5'd0);
    // leap day, then a february 29 that rolls into march
    send_date(12'd1904, 4'd2, 5'd29);
    send_date(12'd1901, 4'd2, 5'd29);
    send_date(12'd1903, 4'd2, 5'd31);
    // 31st of a 30 day month rolls over
    send_date(12'd2000, 4'd4, 5'd31);
    send_date(12'd2099, 4'd11, 5'd31);
    // directed: day numbers at and past both ends, plus leap-year edges
    send_number(17'd0);
    send_number(17'd1);
    send_number(LAST_DAY);
    send_number(LAST_DAY + 17'd1);
    send_number(17'h1ffff);
    send_number(17'd59);
    send_number(17'd60);
    send_number(17'd1155);
    send_number(17'd1156);

    wait_until_drained();

    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) wait_until_drained();
      if (i == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      send_random_word();
    end
    s_tvalid <= 1'b0;

    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d date to number), %0d results checked",
             sb.words_in, sb.to_number_words, sb.results_checked);
    $display("range errors among results: %0d, field mismatches: %0d",
             sb.error_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/dndc_pkg.sv
sv/dndc_core.sv
sv/day_number_date_converter_top.sv
bench/tb_top.sv
